// File: sv/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg: shared types and constants of the radix string-to-integer unit
// Character codes, the parser state record and the result record.
// ----------------------------------------------------------------------------
package rsi_pkg;

	localparam int unsigned MaxLengthDefault = 65535;
	localparam logic [4:0]  RadixReset       = 5'd10;
	localparam logic [4:0]  RadixDec         = 5'd10;
	localparam logic [4:0]  RadixHex         = 5'd16;
	localparam logic [4:0]  RadixMin         = 5'd2;

	localparam logic [7:0] ChNul   = 8'h00;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChPlus  = 8'h2B;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChLowA  = 8'h61;
	localparam logic [7:0] ChLowF  = 8'h66;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpF   = 8'h46;
	localparam logic [7:0] ChLowX  = 8'h78;
	localparam logic [7:0] ChUpX   = 8'h58;

	localparam logic StatusOk       = 1'b0;
	localparam logic StatusBadRadix = 1'b1;

	typedef struct packed {
		logic [63:0] acc;
		logic        neg;
		logic [15:0] pos;
		logic        fin;
	} parse_state_t;

	typedef struct packed {
		logic        status;
		logic [15:0] end_index;
		logic [63:0] value;
	} parse_result_t;

endpackage

// File: sv/rsi_step.sv
// ----------------------------------------------------------------------------
// rsi_step: one character step of the parser
// Classifies the character and forms the next parser state and the result.
// ----------------------------------------------------------------------------
module rsi_step import rsi_pkg::*; #(
	parameter int unsigned MAX_LENGTH = MaxLengthDefault
) (
	input  parse_state_t  cur,
	input  logic [7:0]    ch,
	input  logic          first,
	input  logic [4:0]    radix,
	output parse_state_t  nxt,
	output logic          emit,
	output parse_result_t res
);

	localparam logic [15:0] PosCap = (MAX_LENGTH < 65535) ? 16'(MAX_LENGTH) : 16'hFFFF;

	parse_state_t st;
	logic         bad_radix;
	logic         is_hex;
	logic         is_space;
	logic         is_x;
	logic         hex_ok;
	logic [3:0]   hex_d;
	logic [7:0]   dec_off;
	logic         dec_ok;
	logic         sign_ok;
	logic [63:0]  acc_mac;
	logic [3:0]   digit;
	logic [15:0]  pos_inc;

	always_comb begin
		// a first-flagged character clears the state before it is parsed
		st = cur;
		if (first) begin
			st.acc = '0;
			st.neg = 1'b0;
			st.pos = '0;
			st.fin = 1'b0;
		end

		bad_radix = (radix < RadixMin) || ((radix > RadixDec) && (radix != RadixHex));
		is_hex    = (radix == RadixHex);
		is_space  = (ch == ChSpace) || ((ch >= ChTab) && (ch <= ChCr));
		is_x      = (ch == ChLowX) || (ch == ChUpX);

		hex_ok = 1'b1;
		hex_d  = '0;
		if ((ch >= ChZero) && (ch <= ChNine)) begin
			hex_d = 4'(ch - ChZero);
		end else if ((ch >= ChLowA) && (ch <= ChLowF)) begin
			hex_d = 4'(ch - ChLowA + 8'd10);
		end else if ((ch >= ChUpA) && (ch <= ChUpF)) begin
			hex_d = 4'(ch - ChUpA + 8'd10);
		end else begin
			hex_ok = 1'b0;
		end

		dec_off = ch - ChZero;
		dec_ok  = (ch >= ChZero) && (dec_off < {3'b000, radix});
		sign_ok = (st.pos == '0) && (radix == RadixDec) && ((ch == ChMinus) || (ch == ChPlus));

		digit   = is_hex ? hex_d : dec_off[3:0];
		acc_mac = st.acc * {59'd0, radix} + {60'd0, digit};
		pos_inc = (st.pos < PosCap) ? st.pos + 16'd1 : st.pos;

		nxt           = st;
		emit          = 1'b0;
		res.value     = st.acc;
		res.end_index = st.pos;
		res.status    = StatusOk;

		if (!st.fin) begin
			if (bad_radix) begin
				emit          = 1'b1;
				res.value     = '0;
				res.end_index = '0;
				res.status    = StatusBadRadix;
				nxt.fin       = 1'b1;
			end else if (is_hex) begin
				if (ch == ChNul || (!is_space && !is_x && !hex_ok)) begin
					emit    = 1'b1;
					nxt.fin = 1'b1;
				end else if (is_space) begin
					nxt.pos = pos_inc;
				end else if (is_x) begin
					nxt.acc = '0;
					nxt.pos = pos_inc;
				end else begin
					nxt.acc = acc_mac;
					nxt.pos = pos_inc;
				end
			end else if (sign_ok) begin
				nxt.neg = (ch == ChMinus);
				nxt.pos = pos_inc;
			end else if (dec_ok) begin
				nxt.acc = acc_mac;
				nxt.pos = pos_inc;
			end else begin
				emit      = 1'b1;
				res.value = st.neg ? (64'd0 - st.acc) : st.acc;
				nxt.fin   = 1'b1;
			end
		end
	end

endmodule

// File: sv/radix_string_to_integer_unit.sv
// ----------------------------------------------------------------------------
// radix_string_to_integer_unit: streaming number parser
// Parses one integer per string from a stream of 8-bit characters.
// ----------------------------------------------------------------------------
// Usage:
//   Feed characters on the s_axis group, one per transfer; tuser marks the
//   first character of a string and clears the parser. The first character
//   that is not part of the number (NUL included) produces one result on
//   the m_axis group: value, end index and status. Characters after that are
//   dropped until the next first-flagged character.
//   The radix register is written through cfg_valid/cfg_data (always ready);
//   the user must write it only while no string is in flight; the block does not enforce this.
//   Radix 2..10 and 16 are valid; any other setting answers each string with status 1 and value 0.
// Timing:
//   One character per cycle sustained while m_axis_tready is high. A character
//   is captured in the input register; the parser step (one 64x5
//   multiply-accumulate) runs between that register and the result register,
//   so a result is shown from the result register once the parser step has
//   taken its stopping character from the input register.
// Reset and stall:
//   Reset empties both registers, sets radix 10 and waits for a first flag.
//   While m_axis_tready is low, a held result stalls the parser step and the
//   input register; s_axis_tready drops only when both are occupied.
// ----------------------------------------------------------------------------
module radix_string_to_integer_unit import rsi_pkg::*; #(
	parameter int unsigned MAX_LENGTH = MaxLengthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,     // radix
	// character input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata, // [7:0] ch
	input  logic        s_axis_tuser, // [0] first
	// result output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata  // [63:0] value, [79:64] end_index, [80] status
);

	logic [4:0]    radix_q;
	logic          valid_s1;
	logic [7:0]    ch_s1;
	logic          first_s1;
	parse_state_t  state_q;
	parse_state_t  state_nxt;
	logic          emit;
	parse_result_t res;
	logic          out_valid_q;
	parse_result_t out_q;
	logic          adv;
	logic          proc;

	assign cfg_ready = 1'b1;

	// the parser step may run whenever the result register is free or draining
	assign adv           = !out_valid_q || m_axis_tready;
	assign proc          = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RadixReset;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= cfg_data;
		end
	end

	// input register: hold the character until the parser step takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1    <= s_axis_tdata;
			first_s1 <= s_axis_tuser;
		end
	end

	rsi_step #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_step (
		.cur   (state_q),
		.ch    (ch_s1),
		.first (first_s1),
		.radix (radix_q),
		.nxt   (state_nxt),
		.emit  (emit),
		.res   (res)
	);

	// parser state: advance once per processed character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.acc <= '0;
			state_q.neg <= 1'b0;
			state_q.pos <= '0;
			state_q.fin <= 1'b1;
		end else if (proc) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= proc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_q.status, out_q.end_index, out_q.value};

endmodule
